// ===== hdl/asie_pkg.sv =====
// Package for the sorted insertion table engine: field widths, operation and
// status codes, and the command/status structs between controller and datapath.
// No dependencies.
package asie_pkg;

  localparam int VAL_W       = 32;
  localparam int CNT_W       = 5;
  localparam int IDX_W       = 4;
  localparam int KIND_W      = 3;
  localparam int STAT_W      = 2;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;
  localparam int IN_PAD_W    = IN_TDATA_W - VAL_W - IDX_W;
  localparam int OUT_PAD_W   = OUT_TDATA_W - VAL_W - 1 - CNT_W;

  localparam logic [CNT_W-1:0] CAP_RST = 5'd10;

  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL    = 2'd1;
  localparam logic [STAT_W-1:0] STAT_BAD_IDX = 2'd2;

  typedef enum logic [KIND_W-1:0] {
    KIND_APPEND    = 3'd0,
    KIND_INSERT    = 3'd1,
    KIND_REVERSE   = 3'd2,
    KIND_PARTITION = 3'd3,
    KIND_CHECK     = 3'd4,
    KIND_READ      = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    RD_NONE  = 2'd0,
    RD_PAIR  = 2'd1,
    RD_BELOW = 2'd2,
    RD_IDX   = 2'd3
  } rd_sel_t;

  typedef enum logic [2:0] {
    WR_NONE  = 3'd0,
    WR_VAL_I = 3'd1,
    WR_A_I   = 3'd2,
    WR_B_I   = 3'd3,
    WR_A_J   = 3'd4
  } wr_sel_t;

  typedef enum logic [1:0] {
    PTR_HOLD = 2'd0,
    PTR_INC  = 2'd1,
    PTR_DEC  = 2'd2
  } ptr_op_t;

  typedef enum logic [1:0] {
    INIT_NONE = 2'd0,
    INIT_HOLE = 2'd1,
    INIT_ENDS = 2'd2,
    INIT_CHK  = 2'd3
  } ptr_init_t;

  typedef struct packed {
    logic      load;
    ptr_init_t init;
    ptr_op_t   i_op;
    ptr_op_t   j_op;
    rd_sel_t   rd;
    wr_sel_t   wr;
    logic      cnt_inc;
    logic      set_full;
    logic      set_bad_idx;
    logic      cap_data;
    logic      set_sorted;
    logic      clr_sorted;
    logic      out_load;
  } dp_cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  full;
    logic  i_zero;
    logic  i_lt_j;
    logic  j_lt_cnt;
    logic  a_gt_v;
    logic  a_gt_b;
    logic  a_neg;
    logic  b_neg;
    logic  idx_ok;
  } dp_stat_t;

endpackage

// ===== hdl/array_table_sorted_insert_engine.sv =====
// Sorted insertion table engine, top level. One transaction in, one out.
// Each op steps through the one-write, two-read memory: append and read touch one entry, insert
// shifts larger entries up, reverse and partition swap entries from both ends; check, unused kinds
// and full do no op. A sorted check then scans adjacent pairs up to the first pair out of order.
// Next input taken in the cycle after the result loads; the load waits while out_tready holds off.
// Reset (rst_n, synchronous): count 0, capacity 10, output empty; entries unwritten.
module array_table_sorted_insert_engine import asie_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // value[31:0], index[35:32], zero pad
  input  logic [KIND_W-1:0]      in_tuser,   // kind[2:0]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // data[31:0], is_sorted[32], count[37:33], pad
  output logic [STAT_W-1:0]      out_tuser,  // status[1:0]
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CNT_W-1:0]       cfg_data    // capacity
);

  dp_cmd_t                 cmd;
  dp_stat_t                st;
  logic [STAT_W-1:0]       res_status;
  logic signed [VAL_W-1:0] res_data;
  logic                    res_sorted;
  logic [CNT_W-1:0]        res_count;

  assign cfg_ready = 1'b1;

  asie_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .st         (st),
    .cmd        (cmd)
  );

  asie_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .st         (st),
    .in_kind    (in_tuser),
    .in_value   (in_tdata[VAL_W-1:0]),
    .in_index   (in_tdata[VAL_W +: IDX_W]),
    .cfg_we     (cfg_valid),
    .cfg_cap    (cfg_data),
    .out_status (res_status),
    .out_data   (res_data),
    .out_sorted (res_sorted),
    .out_count  (res_count)
  );

  assign out_tdata = {{OUT_PAD_W{1'b0}}, res_count, res_sorted, res_data};
  assign out_tuser = res_status;

endmodule

// ===== hdl/asie_dp.sv =====
// Datapath of the sorted insertion table engine: entry memory (two registered
// read ports, one write port), pointers, fill count, capacity and result registers.
// Depends on asie_pkg.
module asie_dp import asie_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  dp_cmd_t                 cmd,
  output dp_stat_t                st,
  input  logic [KIND_W-1:0]       in_kind,
  input  logic signed [VAL_W-1:0] in_value,
  input  logic [IDX_W-1:0]        in_index,
  input  logic                    cfg_we,
  input  logic [CNT_W-1:0]        cfg_cap,
  output logic [STAT_W-1:0]       out_status,
  output logic signed [VAL_W-1:0] out_data,
  output logic                    out_sorted,
  output logic [CNT_W-1:0]        out_count
);

  localparam int AW = $clog2(DEPTH);
  localparam int PW = (AW > CNT_W) ? AW : CNT_W;
  localparam logic [CNT_W-1:0] LIM_MAX = (DEPTH > 31) ? 5'd31 : CNT_W'(DEPTH);

  logic signed [VAL_W-1:0] mem [DEPTH];

  logic [CNT_W-1:0]        count_r;
  logic [CNT_W-1:0]        cap_r;
  logic [PW-1:0]           i_r;
  logic [PW-1:0]           j_r;
  kind_t                   kind_r;
  logic signed [VAL_W-1:0] val_r;
  logic [IDX_W-1:0]        idx_r;
  logic signed [VAL_W-1:0] rda_r;
  logic signed [VAL_W-1:0] rdb_r;
  logic [STAT_W-1:0]       status_r;
  logic signed [VAL_W-1:0] data_r;
  logic                    sorted_r;
  logic [STAT_W-1:0]       out_status_r;
  logic signed [VAL_W-1:0] out_data_r;
  logic                    out_sorted_r;
  logic [CNT_W-1:0]        out_count_r;

  logic [CNT_W-1:0]        lim;
  logic [PW-1:0]           cnt_ext;
  logic                    wr_en;
  logic [AW-1:0]           wr_addr;
  logic signed [VAL_W-1:0] wr_data;
  logic                    rd_en;
  logic [AW-1:0]           ra;
  logic [AW-1:0]           rb;

  assign lim     = (cap_r > LIM_MAX) ? LIM_MAX : cap_r;
  assign cnt_ext = PW'(count_r);

  always_comb begin
    st.kind     = kind_r;
    st.full     = (count_r >= lim);
    st.i_zero   = (i_r == '0);
    st.i_lt_j   = (i_r < j_r);
    st.j_lt_cnt = (j_r < cnt_ext);
    st.a_gt_v   = (rda_r > val_r);
    st.a_gt_b   = (rda_r > rdb_r);
    st.a_neg    = rda_r[VAL_W-1];
    st.b_neg    = rdb_r[VAL_W-1];
    st.idx_ok   = (CNT_W'(idx_r) < count_r);
  end

  always_comb begin
    wr_en   = 1'b1;
    wr_addr = AW'(i_r);
    wr_data = val_r;
    case (cmd.wr)
      WR_VAL_I: wr_data = val_r;
      WR_A_I:   wr_data = rda_r;
      WR_B_I:   wr_data = rdb_r;
      WR_A_J: begin
        wr_addr = AW'(j_r);
        wr_data = rda_r;
      end
      default:  wr_en = 1'b0;
    endcase
  end

  always_comb begin
    rd_en = 1'b1;
    ra    = AW'(i_r);
    rb    = AW'(j_r);
    case (cmd.rd)
      RD_PAIR:  ra = AW'(i_r);
      RD_BELOW: ra = AW'(i_r - PW'(1));
      RD_IDX:   ra = AW'(idx_r);
      default:  rd_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rda_r <= mem[ra];
      rdb_r <= mem[rb];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      cap_r   <= CAP_RST;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_cap;
      end
      if (cmd.cnt_inc) begin
        count_r <= count_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.init)
      INIT_HOLE: i_r <= cnt_ext;
      INIT_ENDS: begin
        i_r <= '0;
        j_r <= (count_r == '0) ? '0 : cnt_ext - PW'(1);
      end
      INIT_CHK: begin
        i_r <= '0;
        j_r <= PW'(1);
      end
      default: begin
        case (cmd.i_op)
          PTR_INC: i_r <= i_r + PW'(1);
          PTR_DEC: i_r <= i_r - PW'(1);
          default: i_r <= i_r;
        endcase
        case (cmd.j_op)
          PTR_INC: j_r <= j_r + PW'(1);
          PTR_DEC: j_r <= j_r - PW'(1);
          default: j_r <= j_r;
        endcase
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r   <= kind_t'(in_kind);
      val_r    <= in_value;
      idx_r    <= in_index;
      status_r <= STAT_OK;
      data_r   <= '0;
    end else begin
      if (cmd.set_full) begin
        status_r <= STAT_FULL;
      end
      if (cmd.set_bad_idx) begin
        status_r <= STAT_BAD_IDX;
      end
      if (cmd.cap_data) begin
        data_r <= rda_r;
      end
    end
    if (cmd.set_sorted) begin
      sorted_r <= 1'b1;
    end else if (cmd.clr_sorted) begin
      sorted_r <= 1'b0;
    end
    if (cmd.out_load) begin
      out_status_r <= status_r;
      out_data_r   <= data_r;
      out_sorted_r <= sorted_r;
      out_count_r  <= count_r;
    end
  end

  assign out_status = out_status_r;
  assign out_data   = out_data_r;
  assign out_sorted = out_sorted_r;
  assign out_count  = out_count_r;

endmodule

// ===== hdl/asie_ctrl.sv =====
// Controller of the sorted insertion table engine: one-hot sequencer that
// steps the datapath through each operation and the sorted check; output valid.
// Depends on asie_pkg.
module asie_ctrl import asie_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  output logic     out_tvalid,
  input  logic     out_tready,
  input  dp_stat_t st,
  output dp_cmd_t  cmd
);

  typedef enum logic [13:0] {
    S_IDLE     = 14'b00000000000001,
    S_DISPATCH = 14'b00000000000010,
    S_APP      = 14'b00000000000100,
    S_INS_STEP = 14'b00000000001000,
    S_INS_CMP  = 14'b00000000010000,
    S_REV_RD   = 14'b00000000100000,
    S_REV_DEC  = 14'b00000001000000,
    S_REV_WB   = 14'b00000010000000,
    S_READ     = 14'b00000100000000,
    S_READ_CAP = 14'b00001000000000,
    S_CHK_INIT = 14'b00010000000000,
    S_CHK_RD   = 14'b00100000000000,
    S_CHK_CMP  = 14'b01000000000000,
    S_DONE     = 14'b10000000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (st.kind)
          KIND_APPEND, KIND_INSERT: begin
            if (st.full) begin
              cmd.set_full = 1'b1;
              state_nxt    = S_CHK_INIT;
            end else begin
              cmd.init  = INIT_HOLE;
              state_nxt = (st.kind == KIND_APPEND) ? S_APP : S_INS_STEP;
            end
          end
          KIND_REVERSE, KIND_PARTITION: begin
            cmd.init  = INIT_ENDS;
            state_nxt = S_REV_RD;
          end
          KIND_READ: state_nxt = S_READ;
          default:   state_nxt = S_CHK_INIT;
        endcase
      end
      S_APP: begin
        cmd.wr      = WR_VAL_I;
        cmd.cnt_inc = 1'b1;
        state_nxt   = S_CHK_INIT;
      end
      S_INS_STEP: begin
        if (st.i_zero) begin
          cmd.wr      = WR_VAL_I;
          cmd.cnt_inc = 1'b1;
          state_nxt   = S_CHK_INIT;
        end else begin
          cmd.rd    = RD_BELOW;
          state_nxt = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        if (st.a_gt_v) begin
          cmd.wr    = WR_A_I;
          cmd.i_op  = PTR_DEC;
          state_nxt = S_INS_STEP;
        end else begin
          cmd.wr      = WR_VAL_I;
          cmd.cnt_inc = 1'b1;
          state_nxt   = S_CHK_INIT;
        end
      end
      S_REV_RD: begin
        if (st.i_lt_j) begin
          cmd.rd    = RD_PAIR;
          state_nxt = S_REV_DEC;
        end else begin
          state_nxt = S_CHK_INIT;
        end
      end
      S_REV_DEC: begin
        if (st.kind == KIND_REVERSE) begin
          cmd.wr    = WR_B_I;
          state_nxt = S_REV_WB;
        end else if (st.a_neg) begin
          cmd.i_op  = PTR_INC;
          state_nxt = S_REV_RD;
        end else if (!st.b_neg) begin
          cmd.j_op  = PTR_DEC;
          state_nxt = S_REV_RD;
        end else begin
          cmd.wr    = WR_B_I;
          state_nxt = S_REV_WB;
        end
      end
      S_REV_WB: begin
        cmd.wr    = WR_A_J;
        cmd.i_op  = PTR_INC;
        cmd.j_op  = PTR_DEC;
        state_nxt = S_REV_RD;
      end
      S_READ: begin
        if (st.idx_ok) begin
          cmd.rd    = RD_IDX;
          state_nxt = S_READ_CAP;
        end else begin
          cmd.set_bad_idx = 1'b1;
          state_nxt       = S_CHK_INIT;
        end
      end
      S_READ_CAP: begin
        cmd.cap_data = 1'b1;
        state_nxt    = S_CHK_INIT;
      end
      S_CHK_INIT: begin
        cmd.init  = INIT_CHK;
        state_nxt = S_CHK_RD;
      end
      S_CHK_RD: begin
        if (st.j_lt_cnt) begin
          cmd.rd    = RD_PAIR;
          state_nxt = S_CHK_CMP;
        end else begin
          cmd.set_sorted = 1'b1;
          state_nxt      = S_DONE;
        end
      end
      S_CHK_CMP: begin
        if (st.a_gt_b) begin
          cmd.clr_sorted = 1'b1;
          state_nxt      = S_DONE;
        end else begin
          cmd.i_op  = PTR_INC;
          cmd.j_op  = PTR_INC;
          state_nxt = S_CHK_RD;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid_nxt = (out_valid_r && !out_tready) || cmd.out_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

endmodule
